// ----- rtl/core/gcl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcl_pkg
// Shared widths, constants, coefficient struct and tables for the Gaussian
// class likelihood block.
// ----------------------------------------------------------------------------
package gcl_pkg;

    // Field widths
    localparam int unsigned PIX_W     = 24;
    localparam int unsigned DENS_W    = 32;
    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned CFG_DAT_W = 24;

    // Class count
    localparam int unsigned MAX_CLASSES     = 4;
    localparam int unsigned NUM_CLASSES_DEF = 4;
    localparam int unsigned CLS_W           = 2;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_MEAN_BASE  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIGMA_BASE = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT      = 4'd8;

    // Coefficient formats
    localparam int unsigned SC_E_W = 6;
    localparam int unsigned SC_M_W = 26;
    localparam int unsigned PREF_W = 32;

    // Reset coefficients, sigma of 1.0
    localparam logic [SC_E_W-1:0] SC_E_RST  = 6'd26;
    localparam logic [SC_M_W-1:0] SC_M_RST  = 26'h2000000;
    localparam logic [PREF_W-1:0] PREF_RST  = 32'd6693141;

    // Arithmetic constants
    localparam logic [31:0] PREF_K    = 32'd1713444047;
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [31:0] LN2_Q32   = 32'd2977044472;
    localparam logic [23:0] RECIP6    = 24'd11184811;  // ceil(2^26 / 6)
    localparam logic [5:0]  K_MAX     = 6'd40;

    // Pipeline depth from accepted pixel to result strobe
    localparam int unsigned LATENCY = 15;

    // Divider sequencer: one quotient bit per cycle over a 57 bit dividend
    localparam logic [5:0] DIV_LAST = 6'd56;

    typedef struct packed {
        logic [SC_E_W-1:0] sc_e;
        logic [SC_M_W-1:0] sc_m;
        logic [PREF_W-1:0] pref;
    } gcl_coeff_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_SQUARE,
        SEQ_NORM,
        SEQ_DIVIDE,
        SEQ_STORE
    } seq_state_t;

    // 2^(-i/8) in Q1.30
    function automatic logic [30:0] pow2_eighth(input logic [2:0] idx);
        logic [30:0] val;
        begin
            unique case (idx)
                3'd0: val = 31'd1073741824;
                3'd1: val = 31'd984625594;
                3'd2: val = 31'd902905651;
                3'd3: val = 31'd827968132;
                3'd4: val = 31'd759250125;
                3'd5: val = 31'd696235434;
                3'd6: val = 31'd638450708;
                3'd7: val = 31'd585461881;
            endcase
            return val;
        end
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/gcl_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcl_lane
// Fifteen stage density pipeline for one class: squared distance, scaling,
// range-reduced exp and prefactor multiply with saturation.
// ----------------------------------------------------------------------------
module gcl_lane (
    input  wire logic                        clk,
    input  wire logic [gcl_pkg::PIX_W-1:0]   pixel_value,
    input  wire logic [gcl_pkg::PIX_W-1:0]   mean,
    input  wire gcl_pkg::gcl_coeff_t         coeff,
    output logic      [gcl_pkg::DENS_W-1:0]  density
);
    import gcl_pkg::*;

    // Stage 1: difference
    logic signed [24:0] d_reg;
    // Stage 2: square
    logic [24:0] ad;
    logic [49:0] sq;
    logic [48:0] q_reg;
    // Stage 3: split product
    logic [49:0] ph_reg;
    logic [50:0] pl_reg;
    // Stage 4: recombine
    logic [74:0] full_reg;
    // Stage 5: shift and range check
    logic [5:0]  shamt;
    logic [74:0] tsh;
    logic [28:0] t_reg;
    logic        zero5_reg;
    // Stage 6: to base 2
    logic [59:0] u_prod;
    logic [29:0] u_reg;
    logic        zero6_reg;
    // Stage 7..15 carried fields
    logic [52:0] g_prod;
    logic [28:0] g7_reg, g8_reg, g9_reg, g10_reg;
    logic [57:0] g2_prod;
    logic [25:0] g2_8_reg, g2_9_reg, g2_10_reg;
    logic [54:0] g3_prod;
    logic [22:0] g3_reg;
    logic [46:0] d6_prod;
    logic [20:0] d6_reg;
    logic [32:0] p_reg;
    logic [63:0] mant_prod;
    logic [30:0] mant_reg;
    logic [30:0] e_reg;
    logic [62:0] dens_reg;
    logic [5:0]  k7_reg, k8_reg, k9_reg, k10_reg, k11_reg, k12_reg;
    logic [2:0]  i7_reg, i8_reg, i9_reg, i10_reg, i11_reg;
    logic        z7_reg, z8_reg, z9_reg, z10_reg, z11_reg, z12_reg;
    logic [32:0] dens_q;
    logic [DENS_W-1:0] density_reg;

    // Datapath combinational terms
    assign ad        = d_reg[24] ? 25'(-d_reg) : 25'(d_reg);
    assign sq        = ad * ad;
    assign shamt     = (coeff.sc_e >= 6'd8) ? coeff.sc_e - 6'd8 : 6'd0;
    assign tsh       = full_reg >> shamt;
    assign u_prod    = 60'(t_reg) * 60'(LOG2E_Q30);
    assign g_prod    = 53'(u_reg[20:0]) * 53'(LN2_Q32);
    assign g2_prod   = 58'(g7_reg) * 58'(g7_reg);
    assign g3_prod   = 55'(g2_8_reg) * 55'(g8_reg);
    assign d6_prod   = 47'(g3_reg) * 47'(RECIP6);
    assign mant_prod = 64'(pow2_eighth(i11_reg)) * 64'(p_reg);
    assign dens_q    = dens_reg[62:30];

    // Pipeline registers
    always_ff @(posedge clk)
    begin
        d_reg    <= $signed({pixel_value[PIX_W-1], pixel_value})
                  - $signed({mean[PIX_W-1], mean});
        q_reg    <= sq[48:0];
        ph_reg   <= 50'(q_reg[48:25]) * 50'(coeff.sc_m);
        pl_reg   <= 51'(q_reg[24:0]) * 51'(coeff.sc_m);
        full_reg <= (75'(ph_reg) << 25) + 75'(pl_reg);

        // exponent of 32 or more gives zero density
        t_reg     <= tsh[28:0];
        zero5_reg <= |tsh[74:29];

        u_reg     <= u_prod[59:30];
        zero6_reg <= zero5_reg;

        g7_reg <= g_prod[52:24];
        k7_reg <= u_reg[29:24];
        i7_reg <= u_reg[23:21];
        z7_reg <= zero6_reg;

        g8_reg   <= g7_reg;
        g2_8_reg <= g2_prod[57:32];
        k8_reg   <= k7_reg;
        i8_reg   <= i7_reg;
        z8_reg   <= z7_reg;

        g9_reg    <= g8_reg;
        g2_9_reg  <= g2_8_reg;
        g3_reg    <= g3_prod[54:32];
        k9_reg    <= k8_reg;
        i9_reg    <= i8_reg;
        z9_reg    <= z8_reg;

        g10_reg   <= g9_reg;
        g2_10_reg <= g2_9_reg;
        d6_reg    <= d6_prod[46:26];
        k10_reg   <= k9_reg;
        i10_reg   <= i9_reg;
        z10_reg   <= z9_reg;

        // cubic Taylor term for e^-g
        p_reg   <= (33'd1 << 32) - 33'(g10_reg) + 33'(g2_10_reg >> 1) - 33'(d6_reg);
        k11_reg <= k10_reg;
        i11_reg <= i10_reg;
        z11_reg <= z10_reg;

        mant_reg <= mant_prod[62:32];
        k12_reg  <= k11_reg;
        z12_reg  <= z11_reg;

        e_reg <= (z12_reg || (k12_reg > K_MAX)) ? 31'd0 : (mant_reg >> k12_reg);

        dens_reg <= 63'(coeff.pref) * 63'(e_reg);

        // saturate to Q8.24 range
        density_reg <= dens_q[32] ? {DENS_W{1'b1}} : dens_q[31:0];
    end

    assign density = density_reg;

endmodule
`default_nettype wire

// ----- rtl/core/gaussian_class_likelihood.sv -----
`timescale 1ns / 1ps
`default_nettype none
// An accepted pixel gives its result word, strobed by done, once it has
// passed the lane pipeline registers. Throughput: one pixel per cycle through
// the lane pipelines while busy is low. A sigma write recomputes that class's
// coefficients in a bit-serial divider sequencer (square, normalise shift, 57
// divide steps, store); busy is high and cfg_ready low meanwhile. Reset clears
// means to 0 and sets coefficients for sigma 1.0; results cannot be stalled.
// ----------------------------------------------------------------------------
// gaussian_class_likelihood
// Scores each pixel against up to four Gaussian classes, giving one density
// word per class in Q8.24.
// ----------------------------------------------------------------------------
module gaussian_class_likelihood #(
    parameter int unsigned NUM_CLASSES = gcl_pkg::NUM_CLASSES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [gcl_pkg::PIX_W-1:0]       pixel_value,
    output logic                                 done,
    output logic      [gcl_pkg::DENS_W-1:0]      density_class0,
    output logic      [gcl_pkg::DENS_W-1:0]      density_class1,
    output logic      [gcl_pkg::DENS_W-1:0]      density_class2,
    output logic      [gcl_pkg::DENS_W-1:0]      density_class3,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [gcl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [gcl_pkg::CFG_DAT_W-1:0]   cfg_data
);
    import gcl_pkg::*;

    logic                 accept;
    logic                 cfg_wr;
    logic                 cfg_mean;
    logic                 cfg_sigma;
    logic [LATENCY-1:0]   vld_reg;

    logic [PIX_W-1:0]     mean_reg  [MAX_CLASSES];
    gcl_coeff_t           coeff_reg [MAX_CLASSES];
    logic [DENS_W-1:0]    dens_lane [MAX_CLASSES];

    // Coefficient sequencer
    seq_state_t           state_reg, state_next;
    logic [CLS_W-1:0]     cls_reg;
    logic [23:0]          sig_reg;
    logic [47:0]          q_reg;
    logic [5:0]           z_reg;
    logic [5:0]           cnt_reg;
    logic [31:0]          r1_reg;
    logic [24:0]          r2_reg;
    logic [SC_M_W-1:0]    quo1_reg;
    logic [PREF_W-1:0]    quo2_reg;
    logic [31:0]          num2_reg;
    logic [31:0]          qt;
    logic                 bit1, bit2;
    logic [32:0]          rs1;
    logic [24:0]          rs2;
    logic                 ge1, ge2;
    logic [31:0]          r1n;
    logic [24:0]          r2n;

    assign accept    = start && !busy;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign cfg_mean  = cfg_wr && (cfg_index < REG_SIGMA_BASE);
    assign cfg_sigma = cfg_wr && (cfg_index >= REG_SIGMA_BASE) && (cfg_index < REG_COUNT);

    // Valid bits alongside the lane pipelines
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LATENCY-2:0], accept};
        end
    end

    assign done = vld_reg[LATENCY-1];

    // Configuration store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < MAX_CLASSES; c++)
            begin
                mean_reg[c]       <= '0;
                coeff_reg[c].sc_e <= SC_E_RST;
                coeff_reg[c].sc_m <= SC_M_RST;
                coeff_reg[c].pref <= PREF_RST;
            end
        end
        else
        begin
            if (cfg_mean)
            begin
                mean_reg[cfg_index[CLS_W-1:0]] <= cfg_data;
            end
            if (state_reg == SEQ_STORE)
            begin
                coeff_reg[cls_reg].sc_e <= SC_E_W'(7'd57 - 7'(z_reg));
                coeff_reg[cls_reg].sc_m <= quo1_reg;
                coeff_reg[cls_reg].pref <= quo2_reg;
            end
        end
    end

    // Divider step terms: 2^56 / qt and (K + s/2) / s side by side
    assign qt   = q_reg[47:16];
    assign bit1 = (cnt_reg == DIV_LAST);
    assign bit2 = (cnt_reg < 6'd32) ? num2_reg[cnt_reg[4:0]] : 1'b0;
    assign rs1  = {r1_reg, bit1};
    assign rs2  = {r2_reg[23:0], bit2};
    assign ge1  = rs1 >= {1'b0, qt};
    assign ge2  = rs2 >= {1'b0, sig_reg};
    assign r1n  = ge1 ? 32'(rs1 - {1'b0, qt}) : rs1[31:0];
    assign r2n  = ge2 ? (rs2 - {1'b0, sig_reg}) : rs2;

    // Sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE:   if (cfg_sigma) state_next = SEQ_SQUARE;
            SEQ_SQUARE: state_next = SEQ_NORM;
            SEQ_NORM:   if (q_reg[47]) state_next = SEQ_DIVIDE;
            SEQ_DIVIDE: if (cnt_reg == 6'd0) state_next = SEQ_STORE;
            SEQ_STORE:  state_next = SEQ_IDLE;
            default:    state_next = SEQ_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        busy      = (state_reg != SEQ_IDLE);
        cfg_ready = (state_reg == SEQ_IDLE);
    end

    // Sequencer datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (cfg_sigma)
                begin
                    cls_reg <= cfg_index[CLS_W-1:0];
                    // zero sigma taken as the minimum step
                    sig_reg <= (cfg_data == '0) ? 24'd1 : cfg_data;
                end
            end
            SEQ_SQUARE:
            begin
                q_reg <= 48'(sig_reg) * 48'(sig_reg);
                z_reg <= '0;
            end
            SEQ_NORM:
            begin
                if (!q_reg[47])
                begin
                    q_reg <= q_reg << 1;
                    z_reg <= z_reg + 6'd1;
                end
                else
                begin
                    cnt_reg  <= DIV_LAST;
                    r1_reg   <= '0;
                    r2_reg   <= '0;
                    quo1_reg <= '0;
                    quo2_reg <= '0;
                    num2_reg <= PREF_K + 32'(sig_reg >> 1);
                end
            end
            SEQ_DIVIDE:
            begin
                r1_reg   <= r1n;
                r2_reg   <= r2n;
                quo1_reg <= {quo1_reg[SC_M_W-2:0], ge1};
                quo2_reg <= {quo2_reg[PREF_W-2:0], ge2};
                cnt_reg  <= cnt_reg - 6'd1;
            end
            SEQ_STORE:
            begin
                cnt_reg <= '0;
            end
            default:
            begin
                cnt_reg <= '0;
            end
        endcase
    end

    // Class lanes
    for (genvar c = 0; c < MAX_CLASSES; c++)
    begin : g_lane
        if (c < NUM_CLASSES)
        begin : g_used
            gcl_lane u_lane (
                .clk         (clk),
                .pixel_value (pixel_value),
                .mean        (mean_reg[c]),
                .coeff       (coeff_reg[c]),
                .density     (dens_lane[c])
            );
        end
        else
        begin : g_unused
            assign dens_lane[c] = '0;
        end
    end

    assign density_class0 = dens_lane[0];
    assign density_class1 = dens_lane[1];
    assign density_class2 = dens_lane[2];
    assign density_class3 = dens_lane[3];

endmodule
`default_nettype wire

// ----- tb/tb_gaussian_class_likelihood.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gaussian_class_likelihood
// Self-checking bench for the Gaussian class likelihood block. A directed
// table covers field extremes, ignored register indexes, a zero sigma and
// far-from-mean pixels. Randomised phases then follow, each with new class
// settings. Every result word is compared per class against a typed word or
// a bit-exact fixed-point predictor held in the bench.
// ----------------------------------------------------------------------------
module tb_gaussian_class_likelihood;
    import gcl_pkg::*;

    localparam int unsigned N_CLS = NUM_CLASSES_DEF;
    localparam int unsigned RAND_PHASES = 7;
    localparam int unsigned PIX_PER_PHASE = 100;

    typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_t;
    typedef logic [MAX_CLASSES-1:0][DENS_W-1:0] dens_word_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DAT_W-1:0]   val;
        bit                     typed;
        dens_word_t             want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [PIX_W-1:0] pixel_value = '0;
    logic done;
    logic [DENS_W-1:0] density_class0, density_class1, density_class2, density_class3;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    // predictor copy of the class settings
    logic [PIX_W-1:0] cls_mean [MAX_CLASSES];
    logic [PIX_W-1:0] cls_sigma [MAX_CLASSES];
    logic [31:0]      cls_scale [MAX_CLASSES];
    logic [31:0]      cls_pref [MAX_CLASSES];

    dens_word_t pending_dens[$];
    int unsigned mismatches = 0;
    stim_row_t dir_rows[$];

    always #5 clk = ~clk;

    gaussian_class_likelihood #(.NUM_CLASSES(N_CLS)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .pixel_value(pixel_value), .done(done),
        .density_class0(density_class0), .density_class1(density_class1),
        .density_class2(density_class2), .density_class3(density_class3),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // scale (shift and mantissa) and prefactor from a raw sigma
    task automatic derive_coeffs(input int unsigned c);
        longint unsigned s, q, qt, m;
        int unsigned n;
        s = cls_sigma[c];
        if (s == 0)
            s = 1;
        q = s * s;
        n = 0;
        while (n < 63 && (q >> (n + 1)) != 0)
            n++;
        qt = (n >= 31) ? (q >> (n - 31)) : (q << (31 - n));
        m = (64'd1 << 56) / qt;
        cls_scale[c] = {6'(10 + n), m[25:0]};
        cls_pref[c] = 32'((longint'(PREF_K) + s / 2) / s);
    endtask

    // exp(-t) in Q1.30 with t in Q8.24, t below 32
    function automatic longint unsigned neg_exp(input longint unsigned t);
        longint unsigned u, k, r, g, g2, g3, p, mant;
        logic [2:0] i;
        u = (t * longint'(LOG2E_Q30)) >> 30;
        k = u >> 24;
        i = u[23:21];
        r = u & 64'h1FFFFF;
        g = (r * longint'(LN2_Q32)) >> 24;
        g2 = (g * g) >> 32;
        g3 = (g2 * g) >> 32;
        p = (64'd1 << 32) - g + (g2 >> 1) - g3 / 6;
        case (i)
            3'd0: mant = 64'd1073741824;
            3'd1: mant = 64'd984625594;
            3'd2: mant = 64'd902905651;
            3'd3: mant = 64'd827968132;
            3'd4: mant = 64'd759250125;
            3'd5: mant = 64'd696235434;
            3'd6: mant = 64'd638450708;
            default: mant = 64'd585461881;
        endcase
        mant = (mant * p) >> 32;
        return (k > 40) ? 64'd0 : (mant >> k);
    endfunction

    function automatic logic [31:0] class_dens(input logic [PIX_W-1:0] x, input int unsigned c);
        longint d, ad;
        longint unsigned q, m, hi, lo, t, dens;
        int unsigned e, sh;
        d = longint'($signed(x)) - longint'($signed(cls_mean[c]));
        ad = (d < 0) ? -d : d;
        q = ad * ad;
        m = cls_scale[c][25:0];
        e = cls_scale[c][31:26];
        sh = (e >= 8) ? e - 8 : 0;
        hi = (q >> 25) * m;
        lo = (q & 64'h1FFFFFF) * m;
        if (sh >= 25) begin
            t = (hi + (lo >> 25)) >> (sh - 25);
        end
        else begin
            if (hi >= (64'd1 << 38))
                return 32'd0;
            t = (hi << (25 - sh)) + (lo >> sh);
        end
        if (t >= (64'd1 << 29))
            return 32'd0;
        dens = (longint'(cls_pref[c]) * neg_exp(t)) >> 30;
        return (dens > 64'hFFFFFFFF) ? 32'hFFFFFFFF : dens[31:0];
    endfunction

    function automatic dens_word_t predict_dens(input logic [PIX_W-1:0] x);
        dens_word_t w;
        for (int c = 0; c < MAX_CLASSES; c++)
            w[c] = (c < N_CLS) ? class_dens(x, c) : 32'd0;
        return w;
    endfunction

    task automatic hold_off(input int unsigned n);
        start <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // pixel word; called at a falling edge, returns at one with start left high
    task automatic send_pixel(input logic [PIX_W-1:0] x, input bit typed, input dens_word_t want);
        start <= 1'b1;
        pixel_value <= x;
        do @(posedge clk); while (busy);
        pending_dens = {pending_dens, typed ? want : predict_dens(x)};
        @(negedge clk);
    endtask

    // register write once the pipeline has drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        start <= 1'b0;
        @(negedge clk);
        while (pending_dens.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 2) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx < REG_SIGMA_BASE) begin
            cls_mean[idx] = val;
        end
        else if (idx < REG_COUNT) begin
            cls_sigma[idx - REG_SIGMA_BASE] = val;
            derive_coeffs(idx - REG_SIGMA_BASE);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [CFG_DAT_W-1:0] pick_sigma(input bit edge_only);
        case (edge_only ? $urandom_range(0, 1) : $urandom_range(0, 5))
            0: return 24'h000001;
            1: return 24'hFFFFFF;
            2: return 24'h000100;
            3: return 24'($urandom_range(1, 4096));
            4: return 24'($urandom_range(0, 255));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DAT_W-1:0] pick_mean(input bit edge_only);
        case (edge_only ? $urandom_range(0, 1) : $urandom_range(0, 3))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($urandom_range(0, 65535)) - 24'd32768;
            default: return 24'($urandom);
        endcase
    endfunction

    // mostly within a few sigma of a class mean, the rest anywhere
    function automatic logic [PIX_W-1:0] pick_pixel();
        int unsigned c;
        longint spread, off;
        if ($urandom_range(0, 9) < 3)
            return 24'($urandom);
        c = $urandom_range(0, MAX_CLASSES - 1);
        spread = longint'(cls_sigma[c]) * $urandom_range(1, 6);
        if (spread > 64'h7FFFFF)
            spread = 64'h7FFFFF;
        off = longint'($urandom_range(0, 32'(2 * spread))) - spread;
        return 24'(longint'($signed(cls_mean[c])) + off);
    endfunction

    // result checker
    always @(posedge clk) begin
        dens_word_t got, exp_w;
        if (done) begin
            got = {density_class3, density_class2, density_class1, density_class0};
            if (pending_dens.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, got);
                mismatches++;
            end
            else begin
                exp_w = pending_dens.pop_front();
                for (int c = 0; c < MAX_CLASSES; c++)
                    if (got[c] !== exp_w[c]) begin
                        $display("%0t: density_class%0d expected %h got %h",
                                 $time, c, exp_w[c], got[c]);
                        mismatches++;
                    end
            end
        end
    end

    initial begin
        #2ms;
        $display("tb_gaussian_class_likelihood: done, errors");
        $finish;
    end

    initial begin
        int unsigned burst;
        dens_word_t at_reset, none;
        at_reset = {4{32'd6693141}};
        none = '0;
        for (int c = 0; c < MAX_CLASSES; c++) begin
            cls_mean[c] = '0;
            cls_sigma[c] = 24'd256;
            derive_coeffs(c);
        end

        // directed rows
        dir_rows = '{
            '{ROW_PIXEL, 4'd0, 24'h000000, 1'b1, at_reset},
            '{ROW_PIXEL, 4'd0, 24'h7FFFFF, 1'b1, none},
            '{ROW_PIXEL, 4'd0, 24'h800000, 1'b1, none},
            '{ROW_PIXEL, 4'd0, 24'h000100, 1'b0, none},
            '{ROW_PIXEL, 4'd0, 24'hFFFF00, 1'b0, none},
            '{ROW_REG, REG_COUNT, 24'h000123, 1'b0, none},
            '{ROW_REG, 4'd15, 24'hFFFFFF, 1'b0, none},
            '{ROW_PIXEL, 4'd0, 24'h000000, 1'b1, at_reset},
            '{ROW_REG, REG_MEAN_BASE + 4'd0, 24'h7FFFFF, 1'b0, none},
            '{ROW_REG, REG_MEAN_BASE + 4'd1, 24'h800000, 1'b0, none},
            '{ROW_REG, REG_MEAN_BASE + 4'd2, 24'h000080, 1'b0, none},
            '{ROW_REG, REG_MEAN_BASE + 4'd3, 24'hFFFF80, 1'b0, none},
            '{ROW_REG, REG_SIGMA_BASE + 4'd0, 24'h000000, 1'b0, none},
            '{ROW_REG, REG_SIGMA_BASE + 4'd1, 24'h000001, 1'b0, none},
            '{ROW_REG, REG_SIGMA_BASE + 4'd2, 24'hFFFFFF, 1'b0, none},
            '{ROW_REG, REG_SIGMA_BASE + 4'd3, 24'h000300, 1'b0, none},
            '{ROW_PIXEL, 4'd0, 24'h7FFFFF, 1'b0, none},
            '{ROW_PIXEL, 4'd0, 24'h800000, 1'b0, none},
            '{ROW_PIXEL, 4'd0, 24'h7FFFFE, 1'b0, none},
            '{ROW_PIXEL, 4'd0, 24'h000080, 1'b0, none},
            '{ROW_PIXEL, 4'd0, 24'hFFFF80, 1'b0, none},
            '{ROW_PIXEL, 4'd0, 24'h000000, 1'b0, none},
            '{ROW_PIXEL, 4'd0, 24'h555555, 1'b0, none},
            '{ROW_PIXEL, 4'd0, 24'hAAAAAA, 1'b0, none}
        };

        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_REG)
                write_reg(dir_rows[r].idx, dir_rows[r].val);
            else
                send_pixel(dir_rows[r].val, dir_rows[r].typed, dir_rows[r].want);
        end

        // random phases; the last one uses extreme class settings only
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            for (int r = 0; r < REG_COUNT; r++)
                write_reg(CFG_IDX_W'(r), (r < REG_SIGMA_BASE)
                          ? pick_mean(ph == RAND_PHASES - 1)
                          : pick_sigma(ph == RAND_PHASES - 1));
            burst = 0;
            for (int p = 0; p < PIX_PER_PHASE; p++) begin
                if (burst == 0) begin
                    if ($urandom_range(0, 3) != 0)
                        hold_off($urandom_range(1, 8));
                    burst = $urandom_range(1, 30);
                end
                burst--;
                send_pixel(pick_pixel(), 1'b0, none);
            end
        end

        // drain
        start <= 1'b0;
        for (int w = 0; w < 10000 && pending_dens.size() != 0; w++)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
        if (mismatches == 0 && pending_dens.size() == 0) begin
            $display("tb_gaussian_class_likelihood: done, clean");
        end
        else begin
            if (pending_dens.size() != 0)
                $display("%0t: %0d result words never arrived", $time, pending_dens.size());
            $display("tb_gaussian_class_likelihood: done, errors");
        end
        $finish;
    end

endmodule
